>>> hdl/tft_pkg.sv
// Shared types, codes and sizes of the touch finger tracker.
// Used by tft_state, tft_sqrt, tft_div and touch_finger_tracker; no dependencies.
package tft_pkg;

   // finger slots and sizes that follow from them
   localparam int FINGER_SLOTS = 8;
   localparam int SLOT_W       = $clog2(FINGER_SLOTS);
   localparam int MASK_W       = 8;

   // serial root and divider sizes
   localparam int ROOT_W     = 24;
   localparam int RAD_W      = 2 * ROOT_W;
   localparam int STEP_CNT_W = $clog2(ROOT_W);

   // input actions
   localparam logic [2:0] ACT_DOWN   = 3'd0;
   localparam logic [2:0] ACT_UP     = 3'd1;
   localparam logic [2:0] ACT_MOVE   = 3'd2;
   localparam logic [2:0] ACT_CANCEL = 3'd3;

   // result kinds
   localparam logic [2:0] KIND_BEGIN  = 3'd0;
   localparam logic [2:0] KIND_MOVE   = 3'd1;
   localparam logic [2:0] KIND_END    = 3'd2;
   localparam logic [2:0] KIND_CANCEL = 3'd3;
   localparam logic [2:0] KIND_SWIPE  = 3'd4;

   // one tracked event, as captured at acceptance
   typedef struct packed {
      logic [2:0]               kind;
      logic [14:0]              x;
      logic [14:0]              y;
      logic signed [16:0]       dx;
      logic signed [16:0]       dy;
      logic signed [16:0]       bx;
      logic signed [16:0]       by;
      logic [31:0]              t;
      logic [SLOT_W-1:0]        slot;
      logic [MASK_W-1:0]        mask;
   } item_type;

   // status of a serial unit
   typedef struct packed {
      logic busy;
      logic done;
   } serial_stat_type;

   // true for a known action on a slot that exists
   function automatic logic is_tracked(input logic [2:0] action, input logic [3:0] finger);
      logic known;
      known = (action == ACT_DOWN) || (action == ACT_UP) ||
              (action == ACT_MOVE) || (action == ACT_CANCEL);
      return known && ({1'b0, finger} < 5'(FINGER_SLOTS));
   endfunction

endpackage

>>> hdl/touch_finger_tracker.sv
// Touch finger tracker: control sequencer, displacement squares and result beats.
// Depends on tft_pkg, tft_state, tft_sqrt and tft_div.
//
// Usage: one req beat is one touch event. req_tuser carries the action,
// req_tdata the finger, position and timestamp. Each tracked event yields one
// rsp beat (begin, move, end or cancel); an end is followed by a swipe beat,
// which alone carries rsp_tlast low on the first and high on the second.
// Events with an unknown action or a finger slot past the last are taken and
// dropped with no result.
// Steps: when a speed is computed, an accepted event passes the x square, the y
// square, the serial root, the serial divider and the load; a begin, a cancel or
// zero elapsed ticks go from the x square straight to the load. The root and the
// divider each take one bit per cycle, and the block works on one event at a
// time: a new event is taken only while the sequencer is idle.
// The next event is taken while the previous results still wait in the output
// register; its results are loaded once that register has drained.
// Reset clears all finger positions to -1, start times and the down mask to 0.
// A stalled receiver holds the rsp beat steady and stops the sequencer at load.
module touch_finger_tracker (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // fields from bit 0: finger[3:0], pos_x[14:0], pos_y[14:0], now_ticks[31:0], zero pad
   input  logic [71:0]   req_tdata,
   // fields from bit 0: action[2:0]
   input  logic [2:0]    req_tuser,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // fields from bit 0: out_x[14:0], out_y[14:0], delta_x[15:0], delta_y[15:0],
   // speed[23:0], elapsed[31:0], slot[2:0], down_mask[7:0], zero pad
   output logic [135:0]  rsp_tdata,
   // fields from bit 0: event_kind[2:0]
   output logic [2:0]    rsp_tuser,
   output logic          rsp_tlast
);

   // sequencer states
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_SQX  = 3'd1;
   localparam logic [2:0] S_SQY  = 3'd2;
   localparam logic [2:0] S_ROOT = 3'd3;
   localparam logic [2:0] S_DIV  = 3'd4;
   localparam logic [2:0] S_LOAD = 3'd5;

   logic [2:0] state_ff, state_in;

   // input fields
   logic [2:0]  action;
   logic [3:0]  finger;
   logic [14:0] pos_x, pos_y;
   logic [31:0] now_ticks;
   logic        req_beat, take;

   tft_pkg::item_type        item;
   tft_pkg::serial_stat_type sq_stat, dv_stat;
   logic                     sq_start, dv_start;
   logic [tft_pkg::ROOT_W-1:0] root, quot;

   logic [15:0] mul_a;
   logic [31:0] prod;
   logic [31:0] sqx_ff;
   logic [23:0] spd_ff;
   logic        skip;

   // output register
   logic        out_valid_ff, out_pair_ff, out_last_ff;
   logic [2:0]  out_kind_ff;
   logic [14:0] out_x_ff, out_y_ff;
   logic [15:0] out_dx_ff, out_dy_ff;
   logic [23:0] out_speed_ff;
   logic [31:0] out_elapsed_ff;
   logic [2:0]  out_slot_ff;
   logic [7:0]  out_mask_ff;
   logic        rsp_beat, load;
   logic        is_end, is_cancel;

   // clamp a 17-bit difference to the signed 16-bit range
   function automatic logic [15:0] sat16(input logic signed [16:0] v);
      logic [15:0] r;
      if (v[16] != v[15]) begin
         r = v[16] ? 16'h8000 : 16'h7FFF;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

   // magnitude of a 17-bit difference; at most 32768, so 16 bits hold it
   function automatic logic [15:0] mag16(input logic signed [16:0] v);
      logic [16:0] n;
      n = v[16] ? (17'd0 - v) : v;
      return n[15:0];
   endfunction

   assign action    = req_tuser;
   assign finger    = req_tdata[3:0];
   assign pos_x     = req_tdata[18:4];
   assign pos_y     = req_tdata[33:19];
   assign now_ticks = req_tdata[65:34];

   assign req_tready = (state_ff == S_IDLE);
   assign req_beat   = req_tvalid && req_tready;
   assign take       = req_beat && tft_pkg::is_tracked(action, finger);

   tft_state u_state (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .action    (action),
      .finger    (finger),
      .pos_x     (pos_x),
      .pos_y     (pos_y),
      .now_ticks (now_ticks),
      .item      (item)
   );

   // one shared squarer for both axes
   always_comb begin
      mul_a = (state_ff == S_SQX) ? mag16(item.bx) : mag16(item.by);
      prod  = mul_a * mul_a;
   end

   assign skip     = (item.t == 32'd0) || (item.kind == tft_pkg::KIND_CANCEL);
   assign sq_start = (state_ff == S_SQY);
   assign dv_start = (state_ff == S_ROOT) && sq_stat.done;
   assign rsp_beat = rsp_tvalid && rsp_tready;
   assign load     = (state_ff == S_LOAD) && !out_valid_ff;

   tft_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .start (sq_start),
      .d2    (sqx_ff + prod),
      .stat  (sq_stat),
      .root  (root)
   );

   tft_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (dv_start),
      .dividend (root),
      .divisor  (item.t),
      .stat     (dv_stat),
      .quot     (quot)
   );

   // sequence one event through squares, root and divide
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (take) state_in = S_SQX;
         S_SQX:  state_in = skip ? S_LOAD : S_SQY;
         S_SQY:  state_in = S_ROOT;
         S_ROOT: if (sq_stat.done) state_in = S_DIV;
         S_DIV:  if (dv_stat.done) state_in = S_LOAD;
         S_LOAD: if (!out_valid_ff) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // hold the x square and the speed; the quotient never exceeds the root,
   // so it already fits the 24-bit speed
   always_ff @(posedge clock) begin
      if (state_ff == S_SQX) begin
         sqx_ff <= prod;
         if (skip) begin
            spd_ff <= '0;
         end
      end
      if ((state_ff == S_DIV) && dv_stat.done) begin
         spd_ff <= quot;
      end
   end

   assign is_end    = (item.kind == tft_pkg::KIND_END);
   assign is_cancel = (item.kind == tft_pkg::KIND_CANCEL);

   // output beat control: an end beat is followed by its swipe beat
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         out_pair_ff  <= 1'b0;
      end else if (load) begin
         out_valid_ff <= 1'b1;
         out_pair_ff  <= is_end;
      end else if (rsp_beat) begin
         if (out_pair_ff) begin
            out_pair_ff <= 1'b0;
         end else begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // output payload; turn the end beat into the swipe beat in place
   always_ff @(posedge clock) begin
      if (load) begin
         out_kind_ff    <= item.kind;
         out_x_ff       <= item.x;
         out_y_ff       <= item.y;
         out_dx_ff      <= is_cancel ? 16'h0000 : (is_end ? sat16(item.bx) : sat16(item.dx));
         out_dy_ff      <= is_cancel ? 16'h0000 : (is_end ? sat16(item.by) : sat16(item.dy));
         out_speed_ff   <= spd_ff;
         out_elapsed_ff <= is_end ? item.t : 32'd0;
         out_slot_ff    <= item.slot;
         out_mask_ff    <= item.mask;
         out_last_ff    <= !is_end;
      end else if (rsp_beat && out_pair_ff) begin
         out_kind_ff <= tft_pkg::KIND_SWIPE;
         out_slot_ff <= '0;
         out_mask_ff <= '0;
         out_last_ff <= 1'b1;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = {7'b0000000, out_mask_ff, out_slot_ff, out_elapsed_ff, out_speed_ff,
                        out_dy_ff, out_dx_ff, out_y_ff, out_x_ff};

`ifndef SYNTHESIS
   // an end beat is never the final beat of its event
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser == tft_pkg::KIND_END)) |-> !rsp_tlast)
      else $error("end beat marked last");

   // a swipe beat carries no slot and no mask and closes the event
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser == tft_pkg::KIND_SWIPE)) |->
      (rsp_tlast && (rsp_tdata[128:118] == 11'd0)))
      else $error("swipe beat with slot or mask");

   // a cancel beat reports no motion
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser == tft_pkg::KIND_CANCEL)) |->
      (rsp_tdata[117:30] == 88'd0))
      else $error("cancel beat with motion");

   // the root unit is started only when free
   assert property (@(posedge clock) disable iff (reset)
      sq_start |-> !sq_stat.busy)
      else $error("root unit restarted while busy");

   // the divider is started only when free
   assert property (@(posedge clock) disable iff (reset)
      dv_start |-> !dv_stat.busy)
      else $error("divider restarted while busy");

   // an accepted event enters the sequencer at its x square
   assert property (@(posedge clock) disable iff (reset)
      take |=> (state_ff == S_SQX))
      else $error("accepted event did not enter the sequencer");
`endif

endmodule

>>> hdl/tft_state.sv
// Per-finger position and time store plus the down mask; captures one event.
// Depends on tft_pkg.
module tft_state (
   input  logic                clock,
   input  logic                reset,
   input  logic                take,
   input  logic [2:0]          action,
   input  logic [3:0]          finger,
   input  logic [14:0]         pos_x,
   input  logic [14:0]         pos_y,
   input  logic [31:0]         now_ticks,
   output tft_pkg::item_type   item
);

   logic [15:0] start_x_ff [tft_pkg::FINGER_SLOTS];
   logic [15:0] start_y_ff [tft_pkg::FINGER_SLOTS];
   logic [15:0] prev_x_ff  [tft_pkg::FINGER_SLOTS];
   logic [15:0] prev_y_ff  [tft_pkg::FINGER_SLOTS];
   logic [31:0] start_time_ff [tft_pkg::FINGER_SLOTS];
   logic [tft_pkg::MASK_W-1:0] mask_ff, mask_in;
   tft_pkg::item_type item_ff, item_in;

   logic [tft_pkg::SLOT_W-1:0] idx;
   logic                       begin_hit;
   logic [15:0]                px, py, sx, sy;
   logic [31:0]                st;
   logic [16:0]                cur_x, cur_y;
   logic [2:0]                 kind;

   // pick stored values; a begin uses the new position and time
   always_comb begin
      idx       = finger[tft_pkg::SLOT_W-1:0];
      begin_hit = (action == tft_pkg::ACT_DOWN);
      cur_x     = {2'b00, pos_x};
      cur_y     = {2'b00, pos_y};
      px = begin_hit ? {1'b0, pos_x} : prev_x_ff[idx];
      py = begin_hit ? {1'b0, pos_y} : prev_y_ff[idx];
      sx = begin_hit ? {1'b0, pos_x} : start_x_ff[idx];
      sy = begin_hit ? {1'b0, pos_y} : start_y_ff[idx];
      st = begin_hit ? now_ticks : start_time_ff[idx];

      mask_in = mask_ff;
      kind    = tft_pkg::KIND_MOVE;
      unique case (action)
         tft_pkg::ACT_DOWN: begin
            mask_in[idx] = 1'b1;
            kind = tft_pkg::KIND_BEGIN;
         end
         tft_pkg::ACT_UP: begin
            mask_in[idx] = 1'b0;
            kind = tft_pkg::KIND_END;
         end
         tft_pkg::ACT_CANCEL: begin
            mask_in[idx] = 1'b0;
            kind = tft_pkg::KIND_CANCEL;
         end
         default: begin
            kind = tft_pkg::KIND_MOVE;
         end
      endcase

      item_in.kind = kind;
      item_in.x    = pos_x;
      item_in.y    = pos_y;
      item_in.dx   = cur_x - {px[15], px};
      item_in.dy   = cur_y - {py[15], py};
      item_in.bx   = cur_x - {sx[15], sx};
      item_in.by   = cur_y - {sy[15], sy};
      item_in.t    = now_ticks - st;
      item_in.slot = idx;
      item_in.mask = mask_in;
   end

   // update the finger store on a tracked event
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < tft_pkg::FINGER_SLOTS; i++) begin
            start_x_ff[i]    <= '1;
            start_y_ff[i]    <= '1;
            prev_x_ff[i]     <= '1;
            prev_y_ff[i]     <= '1;
            start_time_ff[i] <= '0;
         end
         mask_ff <= '0;
      end else if (take) begin
         if (begin_hit) begin
            start_x_ff[idx]    <= {1'b0, pos_x};
            start_y_ff[idx]    <= {1'b0, pos_y};
            start_time_ff[idx] <= now_ticks;
         end
         prev_x_ff[idx] <= {1'b0, pos_x};
         prev_y_ff[idx] <= {1'b0, pos_y};
         mask_ff        <= mask_in;
      end
   end

   // hold the captured event
   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= item_in;
      end
   end

   assign item = item_ff;

endmodule

>>> hdl/tft_sqrt.sv
// Bit-serial floor square root of (d2 * 65536), two radicand bits per cycle.
// Depends on tft_pkg.
module tft_sqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [31:0]                   d2,
   output tft_pkg::serial_stat_type      stat,
   output logic [tft_pkg::ROOT_W-1:0]    root
);

   logic [tft_pkg::RAD_W-1:0]      rad_ff;
   logic [tft_pkg::ROOT_W+1:0]     rem_ff;
   logic [tft_pkg::ROOT_W-1:0]     root_ff;
   logic [tft_pkg::STEP_CNT_W-1:0] cnt_ff;
   logic                           busy_ff, done_ff;

   logic [tft_pkg::ROOT_W+3:0] rem_sh, trial, diff;
   logic                       fit;

   // one restoring step: bring down a bit pair, try root*4+1
   always_comb begin
      rem_sh = {rem_ff, rad_ff[tft_pkg::RAD_W-1 -: 2]};
      trial  = {2'b00, root_ff, 2'b01};
      fit    = (rem_sh >= trial);
      diff   = rem_sh - trial;
   end

   // control of the step sequence
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && (cnt_ff == '0)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   // shift the radicand out and the root in
   always_ff @(posedge clock) begin
      if (start) begin
         rad_ff  <= {d2, 16'h0000};
         rem_ff  <= '0;
         root_ff <= '0;
         cnt_ff  <= tft_pkg::STEP_CNT_W'(tft_pkg::ROOT_W - 1);
      end else if (busy_ff) begin
         rad_ff <= {rad_ff[tft_pkg::RAD_W-3:0], 2'b00};
         cnt_ff <= cnt_ff - 1'b1;
         if (fit) begin
            rem_ff  <= diff[tft_pkg::ROOT_W+1:0];
            root_ff <= {root_ff[tft_pkg::ROOT_W-2:0], 1'b1};
         end else begin
            rem_ff  <= rem_sh[tft_pkg::ROOT_W+1:0];
            root_ff <= {root_ff[tft_pkg::ROOT_W-2:0], 1'b0};
         end
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign root      = root_ff;

endmodule

>>> hdl/tft_div.sv
// Bit-serial restoring divider: root over elapsed ticks, one quotient bit per cycle.
// Depends on tft_pkg.
module tft_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [tft_pkg::ROOT_W-1:0]    dividend,
   input  logic [31:0]                   divisor,
   output tft_pkg::serial_stat_type      stat,
   output logic [tft_pkg::ROOT_W-1:0]    quot
);

   logic [tft_pkg::ROOT_W-1:0]     q_ff;
   logic [31:0]                    rem_ff;
   logic [31:0]                    div_ff;
   logic [tft_pkg::STEP_CNT_W-1:0] cnt_ff;
   logic                           busy_ff, done_ff;

   logic [32:0] rem_sh, diff;
   logic        fit;

   // bring down the next dividend bit and try the divisor
   always_comb begin
      rem_sh = {rem_ff, q_ff[tft_pkg::ROOT_W-1]};
      fit    = (rem_sh >= {1'b0, div_ff});
      diff   = rem_sh - {1'b0, div_ff};
   end

   // control of the step sequence
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && (cnt_ff == '0)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   // shift the dividend out and the quotient in
   always_ff @(posedge clock) begin
      if (start) begin
         q_ff   <= dividend;
         rem_ff <= '0;
         div_ff <= divisor;
         cnt_ff <= tft_pkg::STEP_CNT_W'(tft_pkg::ROOT_W - 1);
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - 1'b1;
         q_ff   <= {q_ff[tft_pkg::ROOT_W-2:0], fit};
         rem_ff <= fit ? diff[31:0] : rem_sh[31:0];
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quot      = q_ff;

endmodule

>>> verif/tb_touch_finger_tracker.sv
// Self-checking testbench for touch_finger_tracker: directed touch sequences, then
// random finger gestures with random stalls on both streams, checked by a scoreboard.
// Depends on tft_pkg and the touch_finger_tracker RTL.
`timescale 1ns / 100ps

module tb_touch_finger_tracker;

   localparam logic [2:0]  ACT_IGNORED  = 3'd4;
   localparam logic [2:0]  ACT_TOP_CODE = 3'd7;
   localparam logic [23:0] SPEED_MAX    = 24'hFF_FFFF;
   localparam int RANDOM_ITEMS  = 1500;
   localparam int QUIET_ITEMS   = 200;
   localparam int DRAIN_CYCLES  = 100;
   localparam int STALL_LIMIT   = 4000;

   // one expected rsp beat
   typedef struct {
      logic [2:0]         kind;
      logic [14:0]        x;
      logic [14:0]        y;
      logic signed [15:0] dx;
      logic signed [15:0] dy;
      logic [23:0]        speed;
      logic [31:0]        elapsed;
      logic [2:0]         slot;
      logic [7:0]         mask;
      logic               last;
   } touch_beat_type;

   // finger tracking predictor and queue of expected touch beats
   class touch_scoreboard;
      int             start_x[tft_pkg::FINGER_SLOTS];
      int             start_y[tft_pkg::FINGER_SLOTS];
      int             prev_x[tft_pkg::FINGER_SLOTS];
      int             prev_y[tft_pkg::FINGER_SLOTS];
      logic [31:0]    start_time[tft_pkg::FINGER_SLOTS];
      logic [7:0]     fingers_down;
      touch_beat_type pending_beats[$];
      int             errors;

      function new();
         for (int i = 0; i < tft_pkg::FINGER_SLOTS; i++) begin
            start_x[i] = -1;
            start_y[i] = -1;
            prev_x[i] = -1;
            prev_y[i] = -1;
            start_time[i] = '0;
         end
         fingers_down = '0;
         errors = 0;
      endfunction

      // floor square root, two bits per step
      function logic [63:0] int_root(logic [63:0] value);
         logic [63:0] rem;
         logic [63:0] root;
         logic [63:0] probe;
         rem = value;
         root = '0;
         probe = 64'd1 << 62;
         while (probe > rem)
            probe = probe >> 2;
         while (probe != 0) begin
            if (rem >= root + probe) begin
               rem = rem - (root + probe);
               root = (root >> 1) + probe;
            end else begin
               root = root >> 1;
            end
            probe = probe >> 2;
         end
         return root;
      endfunction

      function logic signed [15:0] clip16(int value);
         if (value > 32767)
            return 16'sh7FFF;
         if (value < -32768)
            return 16'sh8000;
         return value[15:0];
      endfunction

      // update finger state for an accepted event and queue its beats
      function void note_event(logic [2:0] act, logic [3:0] finger, logic [14:0] x,
                               logic [14:0] y, logic [31:0] now);
         touch_beat_type beat;
         int          f;
         int          dx;
         int          dy;
         int          bx;
         int          by;
         logic [31:0] ticks;
         logic [63:0] dist2;
         logic [63:0] quot;
         logic [23:0] spd;
         logic [2:0]  kind;
         if (act > tft_pkg::ACT_CANCEL || finger >= tft_pkg::FINGER_SLOTS)
            return;
         f = finger;
         case (act)
            tft_pkg::ACT_DOWN: begin
               fingers_down[f] = 1'b1;
               kind = tft_pkg::KIND_BEGIN;
            end
            tft_pkg::ACT_UP: begin
               fingers_down[f] = 1'b0;
               kind = tft_pkg::KIND_END;
            end
            tft_pkg::ACT_MOVE: begin
               kind = tft_pkg::KIND_MOVE;
            end
            default: begin
               fingers_down[f] = 1'b0;
               kind = tft_pkg::KIND_CANCEL;
            end
         endcase
         // a begin loads start and previous position first
         if (kind == tft_pkg::KIND_BEGIN) begin
            start_x[f] = int'(x);
            start_y[f] = int'(y);
            prev_x[f] = int'(x);
            prev_y[f] = int'(y);
            start_time[f] = now;
         end
         dx = int'(x) - prev_x[f];
         dy = int'(y) - prev_y[f];
         bx = int'(x) - start_x[f];
         by = int'(y) - start_y[f];
         ticks = now - start_time[f];
         spd = '0;
         if (ticks != 0) begin
            dist2 = longint'(bx) * longint'(bx) + longint'(by) * longint'(by);
            quot = int_root(dist2 << 16) / {32'd0, ticks};
            spd = (quot > SPEED_MAX) ? SPEED_MAX : quot[23:0];
         end
         prev_x[f] = int'(x);
         prev_y[f] = int'(y);
         if (kind == tft_pkg::KIND_CANCEL) begin
            dx = 0;
            dy = 0;
            spd = '0;
         end
         beat.kind = kind;
         beat.x = x;
         beat.y = y;
         beat.speed = spd;
         beat.slot = f[2:0];
         beat.mask = fingers_down;
         if (kind == tft_pkg::KIND_END) begin
            // end then swipe, both with the total displacement
            beat.dx = clip16(bx);
            beat.dy = clip16(by);
            beat.elapsed = ticks;
            beat.last = 1'b0;
            pending_beats.push_back(beat);
            beat.kind = tft_pkg::KIND_SWIPE;
            beat.slot = '0;
            beat.mask = '0;
            beat.last = 1'b1;
            pending_beats.push_back(beat);
         end else begin
            beat.dx = clip16(dx);
            beat.dy = clip16(dy);
            beat.elapsed = '0;
            beat.last = 1'b1;
            pending_beats.push_back(beat);
         end
      endfunction

      function void check_field(string name, logic signed [63:0] expv,
                                logic signed [63:0] gotv);
         if (gotv !== expv) begin
            $error("%s mismatch: expected %0d actual %0d", name, expv, gotv);
            errors++;
         end
      endfunction

      // compare one accepted rsp beat with the oldest expectation
      function void check_beat(logic [135:0] data, logic [2:0] user, logic tlast);
         touch_beat_type want;
         if (pending_beats.size() == 0) begin
            $error("rsp beat with no pending expectation: kind %0d", user);
            errors++;
            return;
         end
         want = pending_beats.pop_front();
         check_field("event_kind", want.kind, user);
         check_field("out_x", want.x, data[14:0]);
         check_field("out_y", want.y, data[29:15]);
         check_field("delta_x", want.dx, $signed(data[45:30]));
         check_field("delta_y", want.dy, $signed(data[61:46]));
         check_field("speed", want.speed, data[85:62]);
         check_field("elapsed", want.elapsed, data[117:86]);
         check_field("slot", want.slot, data[120:118]);
         check_field("down_mask", want.mask, data[128:121]);
         check_field("last", want.last, tlast);
      endfunction

      function int pending_count();
         return pending_beats.size();
      endfunction
   endclass

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   // fields from bit 0: finger[3:0], pos_x[14:0], pos_y[14:0], now_ticks[31:0], zero pad
   logic [71:0]   req_tdata = '0;
   // fields from bit 0: action[2:0]
   logic [2:0]    req_tuser = '0;
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   // fields from bit 0: out_x[14:0], out_y[14:0], delta_x[15:0], delta_y[15:0],
   // speed[23:0], elapsed[31:0], slot[2:0], down_mask[7:0], zero pad
   logic [135:0]  rsp_tdata;
   // fields from bit 0: event_kind[2:0]
   logic [2:0]    rsp_tuser;
   logic          rsp_tlast;

   touch_scoreboard tracker_sb = new();
   bit  quiet = 1'b0;
   int  gap_pct = 25;
   int  idle_cycles = 0;

   touch_finger_tracker uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // drive one touch event, with an optional gap before it, until accepted
   task automatic send_event(input logic [2:0] act, input logic [3:0] finger,
                             input logic [14:0] x, input logic [14:0] y,
                             input logic [31:0] now);
      if (!quiet && $urandom_range(0, 99) < gap_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= act;
      req_tdata <= {6'd0, now, y, x, finger};
      do
         @(posedge clock);
      while (!req_tready);
      tracker_sb.note_event(act, finger, x, y, now);
   endtask

   // receiver: random stall bursts, none in the quiet tail
   initial begin
      @(posedge clock);
      while (reset)
         @(posedge clock);
      forever begin
         if (!quiet && $urandom_range(0, 99) < gap_pct) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // check every accepted rsp beat
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         tracker_sb.check_beat(rsp_tdata, rsp_tuser, rsp_tlast);
   end

   // watchdog on cycles with no beat on either stream
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // stimulus
   initial begin
      int          tracked;
      logic [7:0]  held;
      int          last_x[tft_pkg::FINGER_SLOTS];
      int          last_y[tft_pkg::FINGER_SLOTS];
      logic [31:0] clock_ticks;
      logic [2:0]  act;
      logic [3:0]  f;
      int          nx;
      int          ny;
      int          pick;
      logic [31:0] now;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // moves, ups and cancels with no prior down start from the reset position
      send_event(tft_pkg::ACT_MOVE, 4'd0, 15'h7FFF, 15'h7FFF, 32'd1000);
      send_event(tft_pkg::ACT_UP, 4'd1, 15'd0, 15'd0, 32'd5);
      send_event(tft_pkg::ACT_CANCEL, 4'd3, 15'd123, 15'd456, 32'd9);
      // full-range swing, zero elapsed ticks, then a long hold
      send_event(tft_pkg::ACT_DOWN, 4'd0, 15'd0, 15'd0, 32'd100);
      send_event(tft_pkg::ACT_MOVE, 4'd0, 15'h7FFF, 15'h7FFF, 32'd100);
      send_event(tft_pkg::ACT_MOVE, 4'd0, 15'h7FFF, 15'd0, 32'd101);
      send_event(tft_pkg::ACT_UP, 4'd0, 15'h7FFF, 15'h7FFF, 32'hFFFF_FFFF);
      // timestamp wraps between down and up
      send_event(tft_pkg::ACT_DOWN, 4'd2, 15'h5555, 15'h2AAA, 32'hFFFF_FFF0);
      send_event(tft_pkg::ACT_UP, 4'd2, 15'h2AAA, 15'h5555, 32'h0000_0010);
      // cancel after down, then an up on the canceled finger
      send_event(tft_pkg::ACT_DOWN, 4'd3, 15'd100, 15'd200, 32'd50);
      send_event(tft_pkg::ACT_CANCEL, 4'd3, 15'd300, 15'd400, 32'd60);
      send_event(tft_pkg::ACT_UP, 4'd3, 15'd310, 15'd410, 32'd70);
      // dropped events: unknown actions and slots past the last
      send_event(ACT_IGNORED, 4'd0, 15'd1, 15'd1, 32'd80);
      send_event(ACT_TOP_CODE, 4'd7, 15'h7FFF, 15'h7FFF, 32'hFFFF_FFFF);
      send_event(tft_pkg::ACT_DOWN, 4'd8, 15'd5, 15'd5, 32'd90);
      send_event(tft_pkg::ACT_MOVE, 4'd15, 15'd5, 15'd5, 32'd95);
      // all fingers down, then release the outer two
      for (int i = 0; i < tft_pkg::FINGER_SLOTS; i++)
         send_event(tft_pkg::ACT_DOWN, 4'(i), 15'(i * 4000), 15'(32767 - i * 4000),
                    32'(200 + i));
      send_event(tft_pkg::ACT_UP, 4'd7, 15'd0, 15'd0, 32'd300);
      send_event(tft_pkg::ACT_UP, 4'd0, 15'd32000, 15'd31000, 32'd400);

      // random gestures from the current finger state
      held = 8'h7E;
      for (int i = 0; i < tft_pkg::FINGER_SLOTS; i++) begin
         last_x[i] = i * 4000;
         last_y[i] = 32767 - i * 4000;
      end
      clock_ticks = 32'd1000;
      tracked = 0;
      while (tracked < RANDOM_ITEMS) begin
         if (tracked >= RANDOM_ITEMS - QUIET_ITEMS)
            quiet = 1'b1;
         if (tracked % 100 == 0) begin
            pick = $urandom_range(0, 2);
            gap_pct = (pick == 0) ? 0 : (pick == 1) ? 25 : 60;
         end
         if ($urandom_range(0, 99) < 15) begin
            // noise: any action, any slot, any values
            act = 3'($urandom_range(0, 7));
            f = 4'($urandom_range(0, 15));
            nx = $urandom_range(0, 32767);
            ny = $urandom_range(0, 32767);
            now = $urandom;
         end else begin
            f = 4'($urandom_range(0, tft_pkg::FINGER_SLOTS - 1));
            pick = $urandom_range(0, 99);
            if (!held[f])
               act = tft_pkg::ACT_DOWN;
            else if (pick < 60)
               act = tft_pkg::ACT_MOVE;
            else if (pick < 85)
               act = tft_pkg::ACT_UP;
            else if (pick < 93)
               act = tft_pkg::ACT_CANCEL;
            else
               act = tft_pkg::ACT_DOWN;
            if ($urandom_range(0, 9) == 0) begin
               nx = $urandom_range(0, 32767);
               ny = $urandom_range(0, 32767);
            end else begin
               nx = last_x[f] + $urandom_range(0, 256) - 128;
               ny = last_y[f] + $urandom_range(0, 256) - 128;
               nx = (nx < 0) ? 0 : (nx > 32767) ? 32767 : nx;
               ny = (ny < 0) ? 0 : (ny > 32767) ? 32767 : ny;
            end
            if ($urandom_range(0, 49) == 0)
               clock_ticks = clock_ticks + $urandom;
            else
               clock_ticks = clock_ticks + $urandom_range(0, 3000);
            now = clock_ticks;
         end
         send_event(act, f, 15'(nx), 15'(ny), now);
         if (act <= tft_pkg::ACT_CANCEL && f < tft_pkg::FINGER_SLOTS) begin
            held[f] = (act == tft_pkg::ACT_DOWN) ? 1'b1 :
                      (act == tft_pkg::ACT_MOVE) ? held[f] : 1'b0;
            last_x[f] = nx;
            last_y[f] = ny;
            tracked++;
         end
      end
      req_tvalid <= 1'b0;

      // drain, then allow for a dropped event still in flight
      while (tracker_sb.pending_count() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (tracker_sb.errors == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

>>> touch_finger_tracker.f
hdl/tft_pkg.sv
hdl/tft_state.sv
hdl/tft_sqrt.sv
hdl/tft_div.sv
hdl/touch_finger_tracker.sv
verif/tb_touch_finger_tracker.sv
